/* rtl/vaos_pkg.sv */
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types and codes for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
package vaos_pkg;

  // request codes carried in the request type field
  localparam logic [1:0] REQ_PLAY     = 2'd0;
  localparam logic [1:0] REQ_FINISH   = 2'd1;
  localparam logic [1:0] REQ_STOP_ALL = 2'd2;

  // field widths of the input and result words
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned VOICE_W = 2;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned TDATA_W = 8;

  // operation applied to one pool
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_PLAY,
    OP_FINISH,
    OP_CLEAR
  } pool_op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted input word
    logic exec;      // update the pools and load the result word
  } ctrl_cmd_t;

  // result of one pool step
  typedef struct packed {
    logic [VOICE_W-1:0] granted;
    logic               stolen;
    logic               removed;
    logic [MASK_W-1:0]  mask;
  } pool_res_t;

endpackage

/* rtl/vaos_pool.sv */
// ----------------------------------------------------------------------------
// vaos_pool
// One voice pool: active flags, start-order list and its fill count.
// ----------------------------------------------------------------------------
module vaos_pool #(
  parameter int unsigned NUM_VOICES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  vaos_pkg::pool_op_e            op_i,
  input  logic [vaos_pkg::VOICE_W-1:0]  voice_i,
  output vaos_pkg::pool_res_t           res_o
);

  localparam int unsigned IW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned CW   = $clog2(NUM_VOICES + 1);
  localparam int unsigned CMPW = (IW > vaos_pkg::VOICE_W) ? IW : vaos_pkg::VOICE_W;
  localparam int unsigned MW   = (NUM_VOICES > vaos_pkg::MASK_W) ? NUM_VOICES
                                                                 : vaos_pkg::MASK_W;

  logic [NUM_VOICES-1:0] act_q, act_d;
  logic [IW-1:0]         ord_q [NUM_VOICES];
  logic [IW-1:0]         ord_d [NUM_VOICES];
  logic [CW-1:0]         cnt_q, cnt_d;

  logic                  found;
  logic [IW-1:0]         free_v;
  logic [IW-1:0]         sel_v;
  logic                  hit;
  logic [CMPW-1:0]       voice_ext;
  logic [NUM_VOICES-1:0] seen;
  logic [MW-1:0]         act_ext;
  logic [CMPW-1:0]       sel_ext;

  assign voice_ext = CMPW'(voice_i);

  // lowest-numbered free voice
  always_comb begin
    found  = 1'b0;
    free_v = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        found  = 1'b1;
        free_v = IW'(i);
      end
    end
  end

  // finish target is in range and playing
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (voice_ext == CMPW'(i) && act_q[i]) hit = 1'b1;
    end
  end

  // list positions at or after the finished voice
  always_comb begin
    seen = '0;
    for (int k = 0; k < NUM_VOICES; k++) begin
      if (k > 0) seen[k] = seen[k-1];
      if (k < int'(cnt_q) && CMPW'(ord_q[k]) == voice_ext) seen[k] = 1'b1;
    end
  end

  always_comb begin
    act_d   = act_q;
    ord_d   = ord_q;
    cnt_d   = cnt_q;
    sel_v   = '0;
    res_o   = '0;
    unique case (op_i)
      vaos_pkg::OP_PLAY: begin
        if (found) begin
          sel_v = free_v;
          for (int k = 0; k < NUM_VOICES; k++) begin
            if (CW'(k) == cnt_q) ord_d[k] = free_v;
            if (IW'(k) == free_v) act_d[k] = 1'b1;
          end
          cnt_d = cnt_q + CW'(1);
        end else begin
          // full pool: evict the head and move it to the tail
          sel_v = ord_q[0];
          for (int k = 0; k < NUM_VOICES - 1; k++) ord_d[k] = ord_q[k+1];
          ord_d[NUM_VOICES-1] = ord_q[0];
          res_o.stolen = 1'b1;
        end
      end
      vaos_pkg::OP_FINISH: begin
        if (hit) begin
          for (int k = 0; k < NUM_VOICES; k++) begin
            if (voice_ext == CMPW'(k)) act_d[k] = 1'b0;
          end
          for (int k = 0; k < NUM_VOICES - 1; k++) begin
            if (seen[k]) ord_d[k] = ord_q[k+1];
          end
          cnt_d = cnt_q - CW'(1);
          res_o.removed = 1'b1;
        end
      end
      vaos_pkg::OP_CLEAR: begin
        act_d = '0;
        cnt_d = '0;
      end
      default: ;
    endcase
    sel_ext       = CMPW'(sel_v);
    act_ext       = MW'(act_d);
    res_o.granted = sel_ext[vaos_pkg::VOICE_W-1:0];
    res_o.mask    = act_ext[vaos_pkg::MASK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      cnt_q <= '0;
    end else if (en_i) begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

  // order list is payload: entries beyond the count are never read
  always_ff @(posedge clk_i) begin
    if (en_i) ord_q <= ord_d;
  end

endmodule

/* rtl/vaos_datapath.sv */
// ----------------------------------------------------------------------------
// vaos_datapath
// Input word register, the two voice pools and the result word register.
// ----------------------------------------------------------------------------
module vaos_datapath #(
  parameter int unsigned DEFAULT_VOICES = 4,
  parameter int unsigned FOCUS_VOICES   = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vaos_pkg::ctrl_cmd_t            cmd_i,
  input  logic [vaos_pkg::TDATA_W-1:0]   in_word_i,
  output logic [vaos_pkg::TDATA_W-1:0]   out_word_o
);

  logic [vaos_pkg::REQ_W-1:0]   req_q;
  logic                         pool_q;
  logic [vaos_pkg::VOICE_W-1:0] voice_q;

  vaos_pkg::pool_op_e  sel_op;
  vaos_pkg::pool_op_e  def_op, foc_op;
  vaos_pkg::pool_res_t def_res, foc_res, res;

  // word layout: req_type [1:0], pool [2], voice [4:3]
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= in_word_i[1:0];
      pool_q  <= in_word_i[2];
      voice_q <= in_word_i[4:3];
    end
  end

  always_comb begin
    unique case (req_q)
      vaos_pkg::REQ_PLAY:     sel_op = vaos_pkg::OP_PLAY;
      vaos_pkg::REQ_FINISH:   sel_op = vaos_pkg::OP_FINISH;
      vaos_pkg::REQ_STOP_ALL: sel_op = vaos_pkg::OP_CLEAR;
      default:                sel_op = vaos_pkg::OP_IDLE;
    endcase
  end

  // stop-all reaches both pools, other requests only the addressed one
  assign def_op = (sel_op == vaos_pkg::OP_CLEAR || !pool_q) ? sel_op : vaos_pkg::OP_IDLE;
  assign foc_op = (sel_op == vaos_pkg::OP_CLEAR ||  pool_q) ? sel_op : vaos_pkg::OP_IDLE;

  vaos_pool #(.NUM_VOICES(DEFAULT_VOICES)) u_default_pool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (cmd_i.exec),
    .op_i    (def_op),
    .voice_i (voice_q),
    .res_o   (def_res)
  );

  vaos_pool #(.NUM_VOICES(FOCUS_VOICES)) u_focus_pool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (cmd_i.exec),
    .op_i    (foc_op),
    .voice_i (voice_q),
    .res_o   (foc_res)
  );

  assign res = pool_q ? foc_res : def_res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_word_o <= {res.mask, res.removed, res.stolen, res.granted};
    end
  end

endmodule

/* rtl/vaos_ctrl.sv */
// ----------------------------------------------------------------------------
// vaos_ctrl
// Sequencer: accept a word, run one pool update, hold the result word.
// ----------------------------------------------------------------------------
module vaos_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output vaos_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = (state_q == ST_SEND);

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/voice_allocator_oldest_steal.sv */
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_core
// Two-pool voice allocator that steals the oldest voice when a pool is full.
// ----------------------------------------------------------------------------
// usage
//   slave channel (s_axis_*): one request word per transfer, carrying the
//     request type (play, finish, stop all), the pool and the finished voice
//   master channel (m_axis_*): exactly one result word per request, with the
//     granted voice, the stolen and removed flags and the pool's active mask
//   a play takes the lowest free voice of its pool; in a full pool the voice
//     at the head of the start-order list is reused and moved to the tail
//   finish frees one playing voice; stop all empties both pools
// timing
//   the word is latched at the accepting edge; the pools update and the
//   result word loads, and becomes valid, at the next edge; a new word is
//   taken the cycle after the result is taken, so no word is accepted until
//   the last one has passed the three-step sequencer (idle, update, send)
//   around the single pool update
// reset
//   all voices idle, both lists empty, no result pending
// stall
//   the result word holds steady until taken and no new word is accepted
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_core #(
  parameter int unsigned DEFAULT_VOICES = 4,
  parameter int unsigned FOCUS_VOICES   = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request word
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // req_type [1:0], pool [2], voice [4:3], zero [7:5]
  // result word
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // granted_voice [1:0], was_stolen [2],
                                       // removed [3], active_mask [7:4]
);

  vaos_pkg::ctrl_cmd_t cmd;

  // handshake sequencing
  vaos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  // pools and word registers
  vaos_datapath #(
    .DEFAULT_VOICES (DEFAULT_VOICES),
    .FOCUS_VOICES   (FOCUS_VOICES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (s_axis_tdata_i),
    .out_word_o (m_axis_tdata_o)
  );

endmodule

/* rtl/vaos_checker.sv */
// ----------------------------------------------------------------------------
// vaos_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vaos_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_i,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result word changed while stalled");

  // one word in flight: no accept while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !s_axis_tready_i)
    else $error("request accepted while result pending");

  // an accepted word is followed by busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i && !m_axis_tvalid_i)
    else $error("accept not followed by update cycle");

  // a result is either a steal or a removal, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(m_axis_tdata_i[2] && m_axis_tdata_i[3]))
    else $error("stolen and removed both set");

endmodule

bind voice_allocator_oldest_steal_core vaos_checker u_vaos_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
